[hw/rtl/tkck_pkg.sv]
// ----------------------------------------------------------------------------
// tkck_pkg: shared types and constants for the top-k candidate keeper
// Candidate record layout, ranking helpers, config indexes and the packing
// of the result word.
// ----------------------------------------------------------------------------
package tkck_pkg;

    localparam int TAG_W   = 16;
    localparam int CNT_W   = 12;
    localparam int SET_W   = 8;
    localparam int TOT_W   = 13;
    localparam int LIM_W   = 5;
    localparam int OUTCNT_W = 5;

    // Input item: tdata fields, lowest first
    localparam int IN_W    = 56;

    // Result item: tdata field offsets, lowest first
    localparam int O_KEPT  = 0;
    localparam int O_FOUND = 1;
    localparam int O_TAG   = 2;
    localparam int O_NAT   = 18;
    localparam int O_CAU   = 30;
    localparam int O_COUNT = 42;
    localparam int O_FRONT = 47;
    localparam int O_BEST  = 60;
    localparam int O_WORST = 73;
    localparam int O_USED  = 86;
    localparam int OUT_W   = 88;

    // Config register indexes
    typedef enum logic [0:0] {
        CFG_KEEP_LIMIT = 1'b0,
        CFG_INIT_BOUND = 1'b1
    } t_cfg_idx;

    // Item kinds on tuser
    typedef enum logic [0:0] {
        KIND_CONSIDER = 1'b0,
        KIND_ROTATE   = 1'b1
    } t_kind;

    typedef struct packed {
        logic [SET_W-1:0] start_sz;
        logic [SET_W-1:0] end_sz;
        logic [CNT_W-1:0] caused;
        logic [CNT_W-1:0] natural;
        logic [TAG_W-1:0] tag;
    } t_entry;

    function automatic logic [TOT_W-1:0] ent_total(input t_entry e);
        return TOT_W'(e.natural) + TOT_W'(e.caused);
    endfunction

    // Candidate c (with its total precomputed) ranks ahead of entry e
    function automatic logic beats(input t_entry c, input logic [TOT_W-1:0] c_tot,
                                   input t_entry e);
        logic [TOT_W-1:0] e_tot;
        e_tot = ent_total(e);
        if (c_tot != e_tot) return c_tot < e_tot;
        if (c.caused != e.caused) return c.caused > e.caused;
        if (c.end_sz != e.end_sz) return c.end_sz < e.end_sz;
        return c.start_sz < e.start_sz;
    endfunction

endpackage

[hw/rtl/top_k_candidate_keeper.sv]
// ----------------------------------------------------------------------------
// top_k_candidate_keeper: ordered list of the best candidate records
// Keeps up to keep_limit records best first, inserts ranked candidates and
// rotates the front record to the back on request.
// ----------------------------------------------------------------------------
// Usage: one item at a time; s_axis_tready is high only while the sequencer
// is idle. A consider item (tuser = 0) walks the first N list slots, where N
// is the entry count after the item (at most keep_limit, clamped to
// 1..MAX_KEPT), then loads its result. A rotate item (tuser = 1) walks the
// H held entries before loading its result, or goes straight to the output
// state on an empty list. The entry memory has one read and one write port:
// the list is walked one entry per cycle, one read and one write, through
// one ranking comparator. A stalled result keeps the sequencer in its output
// state until the register frees up. The next item can be accepted while a
// result still waits in the output register. Configuration writes are taken
// any cycle and are meant for idle periods; writing initial_bound reloads the
// best/worst bounds only while the list is empty. The entry memory needs no
// clearing after reset: slots past the held count are never trusted.
// ----------------------------------------------------------------------------
module top_k_candidate_keeper #(
    parameter int MAX_KEPT = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // config write port
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [tkck_pkg::TOT_W-1:0] i_cfg_data,
    // input items
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [15:0] cand_tag, [27:16] natural_count, [39:28] caused_count,
    // [47:40] end_set_size, [55:48] start_set_size
    input  logic [tkck_pkg::IN_W-1:0] s_axis_tdata,
    // [0] kind
    input  logic                      s_axis_tuser,
    // result items
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] kept, [1] found, [17:2] out_tag, [29:18] out_natural,
    // [41:30] out_caused, [46:42] entry_count, [59:47] front_total,
    // [72:60] best_total, [85:73] worst_total, [87:86] zero
    output logic [tkck_pkg::OUT_W-1:0] m_axis_tdata
);
    import tkck_pkg::*;

    localparam int IW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW  = $clog2(MAX_KEPT + 1);
    localparam int LW  = (CW > LIM_W) ? CW : LIM_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ROT,
        S_OUT
    } t_state;

    // entry memory
    t_entry            r_mem [MAX_KEPT];
    t_entry            r_rdata;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;

    // sequencer state
    t_state            r_state,      n_state;
    logic [LIM_W-1:0]  r_keep_limit, n_keep_limit;
    logic [TOT_W-1:0]  r_init_bound, n_init_bound;
    logic [CW-1:0]     r_count,      n_count;
    logic [TOT_W-1:0]  r_low,        n_low;
    logic [TOT_W-1:0]  r_high,       n_high;
    logic [TOT_W-1:0]  r_front_tot,  n_front_tot;
    logic [TOT_W-1:0]  r_front_new,  n_front_new;
    t_entry            r_cand,       n_cand;
    logic [TOT_W-1:0]  r_cand_tot,   n_cand_tot;
    t_entry            r_carry,      n_carry;
    t_entry            r_first,      n_first;
    logic [CW-1:0]     r_idx,        n_idx;
    logic [CW-1:0]     r_held,       n_held;
    logic [CW-1:0]     r_newc,       n_newc;
    logic              r_hit,        n_hit;
    logic              r_kept,       n_kept;
    logic              r_found,      n_found;
    t_entry            r_ret,        n_ret;
    logic              r_m_valid,    n_m_valid;
    logic [OUT_W-1:0]  r_m_data,     n_m_data;

    // working signals
    logic [LW-1:0]     lim_wide;
    logic [CW-1:0]     lim;
    logic [CW-1:0]     clamped;
    logic [CW-1:0]     newc;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    logic              old_valid;
    t_entry            wval;
    logic [TOT_W-1:0]  wtot;
    logic [TOT_W-1:0]  front_val;
    logic [TOT_W-1:0]  front_out;
    t_entry            in_cand;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign in_cand = t_entry'(s_axis_tdata);

    // effective limit: keep_limit clamped to 1..MAX_KEPT
    always_comb begin
        if (r_keep_limit == '0) begin
            lim_wide = LW'(1);
        end else if (LW'(r_keep_limit) > LW'(MAX_KEPT)) begin
            lim_wide = LW'(MAX_KEPT);
        end else begin
            lim_wide = LW'(r_keep_limit);
        end
        lim     = lim_wide[CW-1:0];
        clamped = (r_count > lim) ? lim : r_count;
        newc    = (clamped < lim) ? clamped + CW'(1) : lim;
    end

    assign idx_inc   = r_idx + CW'(1);
    assign idx_dec   = r_idx - CW'(1);
    assign old_valid = (r_idx < r_held);
    assign wtot      = ent_total(wval);
    assign front_val = (r_idx == '0) ? wtot : r_front_new;
    assign front_out = (n_count == '0) ? '0 : n_front_tot;

    always_comb begin
        n_state      = r_state;
        n_keep_limit = r_keep_limit;
        n_init_bound = r_init_bound;
        n_count      = r_count;
        n_low        = r_low;
        n_high       = r_high;
        n_front_tot  = r_front_tot;
        n_front_new  = r_front_new;
        n_cand       = r_cand;
        n_cand_tot   = r_cand_tot;
        n_carry      = r_carry;
        n_first      = r_first;
        n_idx        = r_idx;
        n_held       = r_held;
        n_newc       = r_newc;
        n_hit        = r_hit;
        n_kept       = r_kept;
        n_found      = r_found;
        n_ret        = r_ret;
        n_m_valid    = r_m_valid & ~m_axis_tready;
        n_m_data     = r_m_data;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[IW-1:0];
        wval         = r_rdata;
        mem_re       = 1'b0;
        mem_raddr    = idx_inc[IW-1:0];

        // config writes
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEEP_LIMIT: n_keep_limit = i_cfg_data[LIM_W-1:0];
                CFG_INIT_BOUND: begin
                    n_init_bound = i_cfg_data;
                    if (r_count == '0) begin
                        n_low  = i_cfg_data;
                        n_high = i_cfg_data;
                    end
                end
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cand     = in_cand;
                    n_cand_tot = ent_total(in_cand);
                    n_kept     = 1'b0;
                    n_found    = 1'b0;
                    n_ret      = '0;
                    n_hit      = 1'b0;
                    n_idx      = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    if (t_kind'(s_axis_tuser) == KIND_CONSIDER) begin
                        n_count = clamped;
                        n_held  = clamped;
                        n_newc  = newc;
                        n_state = S_SCAN;
                    end else if (r_count == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_held  = r_count;
                        n_state = S_ROT;
                    end
                end
            end

            // one entry per cycle: find the slot, then ripple the rest back
            S_SCAN: begin
                mem_re = (idx_inc < CW'(MAX_KEPT));
                if (r_hit) begin
                    wval    = r_carry;
                    mem_we  = 1'b1;
                    n_carry = r_rdata;
                end else if (!old_valid) begin
                    // append behind the last held entry
                    wval   = r_cand;
                    mem_we = 1'b1;
                    n_hit  = 1'b1;
                end else if (beats(r_cand, r_cand_tot, r_rdata)) begin
                    wval    = r_cand;
                    mem_we  = 1'b1;
                    n_hit   = 1'b1;
                    n_carry = r_rdata;
                end
                if (r_idx == '0) begin
                    n_front_new = wtot;
                end
                if (idx_inc == r_newc) begin
                    if (n_hit) begin
                        n_count     = r_newc;
                        n_low       = front_val;
                        n_high      = wtot;
                        n_front_tot = front_val;
                        n_kept      = 1'b1;
                    end
                    n_state = S_OUT;
                end else begin
                    n_idx = idx_inc;
                end
            end

            // pull each entry one slot forward, old front goes last
            S_ROT: begin
                mem_re = (idx_inc < CW'(MAX_KEPT));
                if (r_idx == '0) begin
                    n_first = r_rdata;
                end else begin
                    wval      = (r_idx == r_held) ? r_first : r_rdata;
                    mem_we    = 1'b1;
                    mem_waddr = idx_dec[IW-1:0];
                    if (r_idx == CW'(1)) begin
                        n_front_tot = wtot;
                    end
                end
                if (r_idx == r_held) begin
                    n_found = 1'b1;
                    n_ret   = r_first;
                    n_state = S_OUT;
                end else begin
                    n_idx = idx_inc;
                end
            end

            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid                        = 1'b1;
                    n_m_data                         = '0;
                    n_m_data[O_KEPT]                 = r_kept;
                    n_m_data[O_FOUND]                = r_found;
                    n_m_data[O_NAT-1:O_TAG]          = r_ret.tag;
                    n_m_data[O_CAU-1:O_NAT]          = r_ret.natural;
                    n_m_data[O_COUNT-1:O_CAU]        = r_ret.caused;
                    n_m_data[O_FRONT-1:O_COUNT]      = OUTCNT_W'(r_count);
                    n_m_data[O_BEST-1:O_FRONT]       = front_out;
                    n_m_data[O_WORST-1:O_BEST]       = r_low;
                    n_m_data[O_USED-1:O_WORST]       = r_high;
                    n_state                          = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        mem_wdata = wval;
    end

    // entry store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_keep_limit <= LIM_W'(16);
            r_init_bound <= '0;
            r_count      <= '0;
            r_low        <= '0;
            r_high       <= '0;
            r_front_tot  <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_keep_limit <= n_keep_limit;
            r_init_bound <= n_init_bound;
            r_count      <= n_count;
            r_low        <= n_low;
            r_high       <= n_high;
            r_front_tot  <= n_front_tot;
            r_m_valid    <= n_m_valid;
        end
        r_front_new <= n_front_new;
        r_cand      <= n_cand;
        r_cand_tot  <= n_cand_tot;
        r_carry     <= n_carry;
        r_first     <= n_first;
        r_idx       <= n_idx;
        r_held      <= n_held;
        r_newc      <= n_newc;
        r_hit       <= n_hit;
        r_kept      <= n_kept;
        r_found     <= n_found;
        r_ret       <= n_ret;
        r_m_data    <= n_m_data;
    end

endmodule

[hw/rtl/tkck_chk.sv]
// ----------------------------------------------------------------------------
// tkck_chk: port-level checks for the top-k candidate keeper
// Watches the stream and config ports; bound to the top level below.
// ----------------------------------------------------------------------------
module tkck_chk #(
    parameter int MAX_KEPT = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_we,
    input logic                       i_cfg_idx,
    input logic [tkck_pkg::TOT_W-1:0] i_cfg_data,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [tkck_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                       s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [tkck_pkg::OUT_W-1:0] m_axis_tdata
);
    import tkck_pkg::*;

    logic [OUTCNT_W-1:0] out_count;
    assign out_count = m_axis_tdata[O_FRONT-1:O_COUNT];

    // one item in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a second item back to back");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a result is either an insert or a rotate, never both
    a_kept_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[O_KEPT] && m_axis_tdata[O_FOUND]))
        else $error("kept and found both set");

    // nothing returned means zeroed return fields
    a_empty_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[O_FOUND] |->
            m_axis_tdata[O_COUNT-1:O_TAG] == '0)
        else $error("return fields set without a returned entry");

    // list never holds more than its storage
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (MAX_KEPT > 31) || (32'(out_count) <= MAX_KEPT))
        else $error("entry count beyond storage");

endmodule

bind top_k_candidate_keeper tkck_chk #(.MAX_KEPT(MAX_KEPT)) u_tkck_chk (.*);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for top_k_candidate_keeper
// Starts with a directed run over the ranking ties, the field extremes, the
// empty-list rotate and the keep-limit corner values. Then eight random
// phases follow, each writing keep_limit and initial_bound and using one of four idle mixes.
// A behavioral copy of the ranked list predicts every result. Each result is
// checked field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import tkck_pkg::*;

    localparam int MAX_KEPT    = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 95;

    // one input item: kind on tuser, record on tdata (tag in the low bits)
    typedef struct packed {
        t_kind  kind;
        t_entry rec;
    } t_req;

    // result item, laid out exactly as m_axis_tdata (kept at bit 0)
    typedef struct packed {
        logic [1:0]       pad;
        logic [TOT_W-1:0] worst;
        logic [TOT_W-1:0] best;
        logic [TOT_W-1:0] front;
        logic [4:0]       count;
        logic [CNT_W-1:0] caused;
        logic [CNT_W-1:0] natural;
        logic [TAG_W-1:0] tag;
        logic             found;
        logic             kept;
    } t_outcome;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_idx     = 1'b0;
    logic [TOT_W-1:0]    i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    top_k_candidate_keeper #(.MAX_KEPT(MAX_KEPT)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] tag, [27:16] natural, [39:28] caused,
                                         // [47:40] end set, [55:48] start set
        .s_axis_tuser  (s_axis_tuser),   // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] kept, [1] found, [17:2] tag, [29:18] natural,
                                         // [41:30] caused, [46:42] count, [59:47] front,
                                         // [72:60] best, [85:73] worst, [87:86] zero
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- shadow list
    t_entry           ranked_list [MAX_KEPT];
    int               held_entries  = 0;
    logic [TOT_W-1:0] low_bound_m   = '0;
    logic [TOT_W-1:0] high_bound_m  = '0;
    logic [4:0]       limit_reg     = 5'd16;
    logic [TOT_W-1:0] bound_reg     = '0;

    t_req     item_q [$];      // items waiting for the driver
    t_outcome outcome_q [$];   // predicted results, oldest first
    t_req     cur_item;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       error_count    = 0;
    int       cycle_count    = 0;

    function automatic logic [TOT_W-1:0] rec_sum(input t_entry e);
        return TOT_W'(e.natural) + TOT_W'(e.caused);
    endfunction

    // c ranks ahead of e: lower total, then more caused, smaller end set,
    // smaller start set; an exact tie does not rank ahead
    function automatic bit outranks(input t_entry c, input t_entry e);
        if (rec_sum(c) != rec_sum(e)) return rec_sum(c) < rec_sum(e);
        if (c.caused != e.caused) return c.caused > e.caused;
        if (c.end_sz != e.end_sz) return c.end_sz < e.end_sz;
        return c.start_sz < e.start_sz;
    endfunction

    // advance the shadow list by one item and return the result it yields
    function automatic t_outcome keeper_apply(input t_req r);
        t_outcome o;
        t_entry   head;
        int       lim;
        int       pos;
        int       new_cnt;
        bit       hit;
        o   = '0;
        hit = 1'b0;
        if (r.kind == KIND_CONSIDER) begin
            lim = int'(limit_reg);
            if (lim < 1) lim = 1;
            if (lim > MAX_KEPT) lim = MAX_KEPT;
            // a lowered limit trims the tail before ranking
            if (held_entries > lim) held_entries = lim;
            pos = held_entries;
            for (int i = 0; i < held_entries; i++) begin
                if (outranks(r.rec, ranked_list[i])) begin
                    pos = i;
                    hit = 1'b1;
                    break;
                end
            end
            if (hit || held_entries < lim) begin
                new_cnt = (held_entries + 1 > lim) ? lim : held_entries + 1;
                for (int i = new_cnt - 1; i > pos; i--) ranked_list[i] = ranked_list[i-1];
                if (pos < new_cnt) ranked_list[pos] = r.rec;
                held_entries = new_cnt;
                low_bound_m  = rec_sum(ranked_list[0]);
                high_bound_m = rec_sum(ranked_list[held_entries-1]);
                o.kept = 1'b1;
            end
        end else if (held_entries > 0) begin
            // rotate: front goes to the back and is returned; bounds stay put
            head = ranked_list[0];
            for (int i = 0; i + 1 < held_entries; i++) ranked_list[i] = ranked_list[i+1];
            ranked_list[held_entries-1] = head;
            o.found   = 1'b1;
            o.tag     = head.tag;
            o.natural = head.natural;
            o.caused  = head.caused;
        end
        o.count = 5'(held_entries);
        o.front = (held_entries > 0) ? rec_sum(ranked_list[0]) : '0;
        o.best  = low_bound_m;
        o.worst = high_bound_m;
        return o;
    endfunction

    // ---------------------------------------------------------------- driver
    always @(posedge i_clk) begin : drive_items
        logic busy;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                outcome_q.insert(outcome_q.size(), keeper_apply(cur_item));
                busy = 1'b0;
            end
            if (!busy && item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_item = item_q[0];
                item_q.delete(0);
                s_axis_tdata <= cur_item.rec;
                s_axis_tuser <= cur_item.kind;
                busy = 1'b1;
            end
            s_axis_tvalid <= busy;
        end
    end

    // ---------------------------------------------------------------- monitor
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch_results
        t_outcome seen;
        t_outcome want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = t_outcome'(m_axis_tdata);
                if (outcome_q.size() == 0) begin
                    $error("result item with no item outstanding");
                    error_count++;
                end else begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    check_field("kept",        want.kept,    seen.kept);
                    check_field("found",       want.found,   seen.found);
                    check_field("out_tag",     want.tag,     seen.tag);
                    check_field("out_natural", want.natural, seen.natural);
                    check_field("out_caused",  want.caused,  seen.caused);
                    check_field("entry_count", want.count,   seen.count);
                    check_field("front_total", want.front,   seen.front);
                    check_field("best_total",  want.best,    seen.best);
                    check_field("worst_total", want.worst,   seen.worst);
                    check_field("pad",         want.pad,     seen.pad);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_item(input t_kind kind, input int tag, input int nat, input int cau,
                            input int end_sz, input int start_sz);
        t_req r;
        r.kind         = kind;
        r.rec.tag      = TAG_W'(tag);
        r.rec.natural  = CNT_W'(nat);
        r.rec.caused   = CNT_W'(cau);
        r.rec.end_sz   = SET_W'(end_sz);
        r.rec.start_sz = SET_W'(start_sz);
        item_q.insert(item_q.size(), r);
    endtask

    // mix of full-range records and narrow ones that collide on totals
    task automatic add_random_item();
        int nat;
        int cau;
        int esz;
        int ssz;
        case ($urandom_range(2))
            0: begin nat = $urandom_range(4095);      cau = $urandom_range(4095);      end
            1: begin nat = $urandom_range(7);         cau = $urandom_range(7);         end
            default: begin nat = $urandom_range(4095, 4088); cau = $urandom_range(40); end
        endcase
        if ($urandom_range(1)) begin
            esz = $urandom_range(255);
            ssz = $urandom_range(255);
        end else begin
            esz = $urandom_range(2);
            ssz = $urandom_range(2);
        end
        add_item(($urandom_range(99) < 25) ? KIND_ROTATE : KIND_CONSIDER,
                 $urandom_range(16'hFFFF), nat, cau, esz, ssz);
    endtask

    // sender holds off until the block has returned everything
    task automatic wait_drained();
        while (item_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // register write while idle; shadow copy updated alongside
    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= TOT_W'(value);
        if (idx == CFG_KEEP_LIMIT) begin
            limit_reg = 5'(value);
        end else begin
            bound_reg = TOT_W'(value);
            if (held_entries == 0) begin
                low_bound_m  = bound_reg;
                high_bound_m = bound_reg;
            end
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int limits [PHASES];
        int bounds [PHASES];
        limits = '{16, 1, 0, 31, 7, 16, 3, 16};
        bounds = '{8190, 0, 1234, 8190, 0, 4095, 17, 2048};
        limits[7] = $urandom_range(16, 1);
        bounds[7] = $urandom_range(8190);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, reset defaults first
        add_item(KIND_ROTATE, 16'h1234, 1, 2, 3, 4);        // rotate on empty list
        wait_drained();
        write_reg(CFG_INIT_BOUND, 4321);                    // empty: bounds reload
        add_item(KIND_ROTATE, 0, 0, 0, 0, 0);
        add_item(KIND_CONSIDER, 16'hFFFF, 4095, 4095, 255, 255);  // largest total
        add_item(KIND_CONSIDER, 16'h0000, 0, 0, 0, 0);            // zero total goes first
        add_item(KIND_CONSIDER, 16'h1111, 60, 40, 10, 10);
        add_item(KIND_CONSIDER, 16'h2222, 50, 50, 10, 10);        // tie, more caused
        add_item(KIND_CONSIDER, 16'h3333, 50, 50, 5, 10);         // tie, smaller end set
        add_item(KIND_CONSIDER, 16'h4444, 50, 50, 5, 3);          // tie, smaller start set
        add_item(KIND_CONSIDER, 16'h5555, 50, 50, 5, 3);          // exact tie lands behind
        add_item(KIND_ROTATE, 0, 0, 0, 0, 0);
        add_item(KIND_ROTATE, 0, 0, 0, 0, 0);
        add_item(KIND_ROTATE, 0, 0, 0, 0, 0);
        wait_drained();
        write_reg(CFG_INIT_BOUND, 77);                      // list not empty: no reload
        write_reg(CFG_KEEP_LIMIT, 3);                       // below held count
        add_item(KIND_ROTATE, 0, 0, 0, 0, 0);               // rotates the untrimmed list
        add_item(KIND_CONSIDER, 16'h6666, 4000, 4000, 0, 0);      // trims, then rejected
        add_item(KIND_CONSIDER, 16'h0AAA, 1, 1, 0, 0);
        wait_drained();
        write_reg(CFG_KEEP_LIMIT, 0);                       // acts as a limit of one
        add_item(KIND_CONSIDER, 16'h7777, 2500, 2500, 9, 9);
        add_item(KIND_CONSIDER, 16'h8888, 0, 0, 1, 1);
        add_item(KIND_ROTATE, 0, 0, 0, 0, 0);
        wait_drained();
        write_reg(CFG_KEEP_LIMIT, 31);                      // clamps to the maximum
        add_item(KIND_CONSIDER, 16'hAAAA, 12'h555, 12'hAAA, 8'h55, 8'hAA);
        add_item(KIND_CONSIDER, 16'h5555, 12'hAAA, 12'h555, 8'hAA, 8'h55);
        add_item(KIND_CONSIDER, 16'hFFFF, 0, 4095, 0, 255);
        add_item(KIND_CONSIDER, 16'h0001, 4095, 0, 255, 0);
        add_item(KIND_ROTATE, 0, 0, 0, 0, 0);
        wait_drained();

        // ---- random phases, each with its settings written anew and one of four idle mixes
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_KEEP_LIMIT, limits[p]);
            write_reg(CFG_INIT_BOUND, bounds[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) add_random_item();
            wait_drained();
        end

        // a consider walks at most MAX_KEPT entries; leave room for strays
        repeat (4 * MAX_KEPT) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $error("%0d expected results never arrived", outcome_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
